// ===== sv/via_pkg.sv =====
`timescale 1ns / 1ps

package via_pkg;

	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	localparam logic [3:0] REG_PORT_A   = 4'd0;
	localparam logic [3:0] REG_PORT_B   = 4'd1;
	localparam logic [3:0] REG_DDR_A    = 4'd2;
	localparam logic [3:0] REG_DDR_B    = 4'd3;
	localparam logic [3:0] REG_T1_LO    = 4'd4;
	localparam logic [3:0] REG_T1_HI    = 4'd5;
	localparam logic [3:0] REG_T1_LL    = 4'd6;
	localparam logic [3:0] REG_T1_LH    = 4'd7;
	localparam logic [3:0] REG_T2_HI    = 4'd9;
	localparam logic [3:0] REG_ACR      = 4'd11;
	localparam logic [3:0] REG_IFR      = 4'd13;
	localparam logic [3:0] REG_IER      = 4'd14;

	localparam int IFR_T1_BIT = 6;
	localparam int IFR_T2_BIT = 5;

	typedef struct packed {
		logic       action;
		logic [3:0] reg_index;
		logic [7:0] write_data;
		logic [7:0] port_a_pins;
		logic [7:0] port_b_pins;
	} via_req_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        buzzer_level;
		logic [15:0] timer_one_count;
	} via_rsp_t;

endpackage

// ===== sv/via_register_bank.sv =====
// An accepted request sits in the request register, then moves to the result register
//   when the output is not stalled. Throughput: one request per cycle while rsp_stall
//   is low; the register file is read, updated and the result formed between the two.
// Reset: arst_n clears all sixteen registers, the buzzer level, timer 1 and
//   both valid flags at once; the block takes requests as soon as reset is released.
`timescale 1ns / 1ps

module via_register_bank (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  via_pkg::via_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output via_pkg::via_rsp_t rsp
);

	via_pkg::via_req_t req_s1;
	logic              valid_s1;
	via_pkg::via_rsp_t rsp_s2;
	logic              valid_s2;
	via_pkg::via_rsp_t rsp_next;
	logic              advance;
	logic              take;

	assign advance   = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign take      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!rsp_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_s2 <= rsp_next;
		end
	end

	via_access u_access (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.req    (req_s1),
		.rsp    (rsp_next)
	);

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

`ifndef SYNTH
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1)
		else $error("request stalled with empty input stage");

	a_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1.action == via_pkg::ACT_WRITE |=> rsp.read_data == 8'h00)
		else $error("write returned nonzero read data");

	a_t1_load: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1.action == via_pkg::ACT_WRITE
			&& req_s1.reg_index == via_pkg::REG_T1_HI
		|=> rsp.timer_one_count[15:8] == $past(req_s1.write_data))
		else $error("timer 1 high write did not load counter");

	a_ier_bit7: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1.action == via_pkg::ACT_READ && req_s1.reg_index == via_pkg::REG_IER
		|=> rsp.read_data[7])
		else $error("enable read missing bit 7");
`endif

endmodule

// ===== sv/via_access.sv =====
`timescale 1ns / 1ps

module via_access (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              commit,
	input  via_pkg::via_req_t req,
	output via_pkg::via_rsp_t rsp
);

	logic [7:0]  regs_q [16];
	logic [7:0]  regs_d [16];
	logic        buzz_q;
	logic        buzz_d;
	logic [15:0] t1_q;
	logic [15:0] t1_d;
	logic [7:0]  rd;
	logic        was_auto;
	logic        is_auto;

	always_comb begin
		regs_d   = regs_q;
		buzz_d   = buzz_q;
		t1_d     = t1_q;
		rd       = '0;
		was_auto = &regs_q[via_pkg::REG_ACR][7:6];
		is_auto  = &req.write_data[7:6];
		if (req.action == via_pkg::ACT_WRITE) begin
			case (req.reg_index)
				via_pkg::REG_PORT_A: begin
					regs_d[via_pkg::REG_PORT_A] = req.write_data;
					if (regs_q[via_pkg::REG_DDR_A][7]) begin
						buzz_d = req.write_data[7];
					end
				end
				via_pkg::REG_T1_HI: begin
					regs_d[via_pkg::REG_T1_HI] = req.write_data;
					regs_d[via_pkg::REG_T1_LH] = req.write_data;
					regs_d[via_pkg::REG_T1_LL] = regs_q[via_pkg::REG_T1_LO];
					t1_d = {req.write_data, regs_q[via_pkg::REG_T1_LO]};
				end
				via_pkg::REG_T2_HI: begin
					regs_d[via_pkg::REG_T2_HI] = req.write_data;
					regs_d[via_pkg::REG_IFR][via_pkg::IFR_T2_BIT] = 1'b1;
				end
				via_pkg::REG_IFR: begin
					regs_d[via_pkg::REG_IFR] = regs_q[via_pkg::REG_IFR] & ~req.write_data;
				end
				via_pkg::REG_IER: begin
					if (req.write_data[7]) begin
						regs_d[via_pkg::REG_IER] = regs_q[via_pkg::REG_IER]
							| {1'b0, req.write_data[6:0]};
					end else begin
						regs_d[via_pkg::REG_IER] = regs_q[via_pkg::REG_IER]
							& ~{1'b0, req.write_data[6:0]};
					end
				end
				via_pkg::REG_ACR: begin
					regs_d[via_pkg::REG_ACR] = req.write_data;
					// leaving auto-toggle hands the buzzer back to the port latch
					if (was_auto && !is_auto) begin
						buzz_d = regs_q[via_pkg::REG_PORT_A][7];
					end
				end
				default: begin
					regs_d[req.reg_index] = req.write_data;
				end
			endcase
		end else begin
			case (req.reg_index)
				via_pkg::REG_PORT_A: begin
					rd = (regs_q[via_pkg::REG_PORT_A] & regs_q[via_pkg::REG_DDR_A])
						| (req.port_a_pins & ~regs_q[via_pkg::REG_DDR_A]);
				end
				via_pkg::REG_PORT_B: begin
					rd = (regs_q[via_pkg::REG_PORT_B] & regs_q[via_pkg::REG_DDR_B])
						| (req.port_b_pins & ~regs_q[via_pkg::REG_DDR_B]);
				end
				via_pkg::REG_IFR: begin
					rd = {|(regs_q[via_pkg::REG_IFR][6:0] & regs_q[via_pkg::REG_IER][6:0]),
						regs_q[via_pkg::REG_IFR][6:0]};
				end
				via_pkg::REG_IER: begin
					rd = regs_q[via_pkg::REG_IER] | 8'h80;
				end
				via_pkg::REG_T1_HI: begin
					rd = regs_q[via_pkg::REG_T1_HI];
					regs_d[via_pkg::REG_IFR][via_pkg::IFR_T1_BIT] = 1'b0;
				end
				via_pkg::REG_T2_HI: begin
					rd = regs_q[via_pkg::REG_T2_HI];
					regs_d[via_pkg::REG_IFR][via_pkg::IFR_T2_BIT] = 1'b0;
				end
				default: begin
					rd = regs_q[req.reg_index];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				regs_q[i] <= '0;
			end
			buzz_q <= 1'b0;
			t1_q   <= '0;
		end else if (commit) begin
			regs_q <= regs_d;
			buzz_q <= buzz_d;
			t1_q   <= t1_d;
		end
	end

	assign rsp.read_data       = rd;
	assign rsp.buzzer_level    = buzz_d;
	assign rsp.timer_one_count = t1_d;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int QUIET_ITEMS  = 150;
	localparam int RANDOM_ITEMS = 1025;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 80;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	via_pkg::via_req_t req = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	via_pkg::via_rsp_t rsp;

	// shadow of the register bank
	logic [7:0]  via_regs [16];
	logic        buzzer_q;
	logic [15:0] t1_count;

	via_pkg::via_req_t pending [$];
	via_pkg::via_rsp_t expected_rsp [$];

	int total_items;
	int rsp_seen;
	int errors;
	int send_gap;
	int stall_left;
	int hold_left;
	bit hold_done;

	via_register_bank dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	// Apply one bus access to the shadow bank and return the response it produces.
	// Index 0 pairs with the port_a pin field and index 1 with port_b.
	function automatic via_pkg::via_rsp_t apply_access(via_pkg::via_req_t a);
		via_pkg::via_rsp_t r;
		logic [7:0]        d;
		d = a.write_data;
		r = '0;
		if (a.action == via_pkg::ACT_WRITE) begin
			case (a.reg_index)
				via_pkg::REG_PORT_A: begin
					via_regs[via_pkg::REG_PORT_A] = d;
					if (via_regs[via_pkg::REG_DDR_A][7])
						buzzer_q = d[7];
				end
				via_pkg::REG_T1_HI: begin
					via_regs[via_pkg::REG_T1_HI] = d;
					via_regs[via_pkg::REG_T1_LH] = d;
					via_regs[via_pkg::REG_T1_LL] = via_regs[via_pkg::REG_T1_LO];
					t1_count = {d, via_regs[via_pkg::REG_T1_LO]};
				end
				via_pkg::REG_T2_HI: begin
					via_regs[via_pkg::REG_T2_HI] = d;
					via_regs[via_pkg::REG_IFR][via_pkg::IFR_T2_BIT] = 1'b1;
				end
				via_pkg::REG_IFR: via_regs[via_pkg::REG_IFR] = via_regs[via_pkg::REG_IFR] & ~d;
				via_pkg::REG_IER: begin
					if (d[7])
						via_regs[via_pkg::REG_IER] = via_regs[via_pkg::REG_IER]
							| {1'b0, d[6:0]};
					else
						via_regs[via_pkg::REG_IER] = via_regs[via_pkg::REG_IER]
							& ~{1'b0, d[6:0]};
				end
				via_pkg::REG_ACR: begin
					// leaving auto-toggle mode drops the buzzer back to the port latch
					if (via_regs[via_pkg::REG_ACR][7:6] == 2'b11 && d[7:6] != 2'b11)
						buzzer_q = via_regs[via_pkg::REG_PORT_A][7];
					via_regs[via_pkg::REG_ACR] = d;
				end
				default: via_regs[a.reg_index] = d;
			endcase
		end else begin
			case (a.reg_index)
				via_pkg::REG_PORT_A: r.read_data =
					(via_regs[via_pkg::REG_PORT_A] & via_regs[via_pkg::REG_DDR_A]) |
					(a.port_a_pins & ~via_regs[via_pkg::REG_DDR_A]);
				via_pkg::REG_PORT_B: r.read_data =
					(via_regs[via_pkg::REG_PORT_B] & via_regs[via_pkg::REG_DDR_B]) |
					(a.port_b_pins & ~via_regs[via_pkg::REG_DDR_B]);
				via_pkg::REG_IFR: r.read_data =
					{|(via_regs[via_pkg::REG_IFR][6:0] & via_regs[via_pkg::REG_IER][6:0]),
					via_regs[via_pkg::REG_IFR][6:0]};
				via_pkg::REG_IER: r.read_data = via_regs[via_pkg::REG_IER] | 8'h80;
				via_pkg::REG_T1_HI: begin
					r.read_data = via_regs[via_pkg::REG_T1_HI];
					via_regs[via_pkg::REG_IFR][via_pkg::IFR_T1_BIT] = 1'b0;
				end
				via_pkg::REG_T2_HI: begin
					r.read_data = via_regs[via_pkg::REG_T2_HI];
					via_regs[via_pkg::REG_IFR][via_pkg::IFR_T2_BIT] = 1'b0;
				end
				default: r.read_data = via_regs[a.reg_index];
			endcase
		end
		r.buzzer_level = buzzer_q;
		r.timer_one_count = t1_count;
		return r;
	endfunction

	function automatic void queue_access(logic act, logic [3:0] idx, logic [7:0] d,
		logic [7:0] pa, logic [7:0] pb);
		via_pkg::via_req_t a;
		a.action = act;
		a.reg_index = idx;
		a.write_data = d;
		a.port_a_pins = pa;
		a.port_b_pins = pb;
		pending.push_back(a);
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				expected_rsp.push_back(apply_access(req));
			if (!req_valid || !req_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (pending.size() > QUIET_ITEMS && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(0, 12);
					req_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					req <= pending.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and stall generator
	always @(posedge clk) begin
		via_pkg::via_rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				rsp_seen++;
				if (expected_rsp.size() == 0) begin
					errors++;
					$display("%0t: unexpected response %p", $time, rsp);
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.read_data !== want.read_data) begin
						errors++;
						$display("%0t: read_data expected %02h actual %02h",
							$time, want.read_data, rsp.read_data);
					end
					if (rsp.buzzer_level !== want.buzzer_level) begin
						errors++;
						$display("%0t: buzzer_level expected %0b actual %0b",
							$time, want.buzzer_level, rsp.buzzer_level);
					end
					if (rsp.timer_one_count !== want.timer_one_count) begin
						errors++;
						$display("%0t: timer_one_count expected %04h actual %04h",
							$time, want.timer_one_count, rsp.timer_one_count);
					end
				end
			end
			// hold off long enough once for the block to back up into its input
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (!hold_done && rsp_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				rsp_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if (rsp_seen < total_items - QUIET_ITEMS && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 12);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		for (int i = 0; i < 16; i++)
			via_regs[i] = 8'h00;
		buzzer_q = 1'b0;
		t1_count = 16'h0000;

		// directed: port mixing, buzzer paths, timer loads, flag set and clear
		queue_access(via_pkg::ACT_READ,  via_pkg::REG_PORT_A, 8'h00, 8'hFF, 8'h00);
		queue_access(via_pkg::ACT_READ,  via_pkg::REG_PORT_B, 8'hFF, 8'h00, 8'hFF);
		queue_access(via_pkg::ACT_WRITE, via_pkg::REG_DDR_A,  8'hF0, 8'h00, 8'h00);
		queue_access(via_pkg::ACT_WRITE, via_pkg::REG_PORT_A, 8'hA5, 8'h00, 8'h00);
		queue_access(via_pkg::ACT_READ,  via_pkg::REG_PORT_A, 8'h00, 8'h5A, 8'h00);
		queue_access(via_pkg::ACT_WRITE, via_pkg::REG_DDR_B,  8'h0F, 8'h00, 8'h00);
		queue_access(via_pkg::ACT_WRITE, via_pkg::REG_PORT_B, 8'h3C, 8'h00, 8'h00);
		queue_access(via_pkg::ACT_READ,  via_pkg::REG_PORT_B, 8'h00, 8'h00, 8'hFF);
		queue_access(via_pkg::ACT_WRITE, via_pkg::REG_T1_LO,  8'hFF, 8'h00, 8'h00);
		queue_access(via_pkg::ACT_WRITE, via_pkg::REG_T1_HI,  8'hFF, 8'h00, 8'h00);
		queue_access(via_pkg::ACT_READ,  via_pkg::REG_T1_LL,  8'h00, 8'h00, 8'h00);
		queue_access(via_pkg::ACT_WRITE, via_pkg::REG_T2_HI,  8'h12, 8'h00, 8'h00);
		queue_access(via_pkg::ACT_WRITE, via_pkg::REG_IER,    8'hA0, 8'h00, 8'h00);
		queue_access(via_pkg::ACT_READ,  via_pkg::REG_IFR,    8'h00, 8'h00, 8'h00);
		queue_access(via_pkg::ACT_READ,  via_pkg::REG_IER,    8'h00, 8'h00, 8'h00);
		queue_access(via_pkg::ACT_READ,  via_pkg::REG_T2_HI,  8'h00, 8'h00, 8'h00);
		queue_access(via_pkg::ACT_READ,  via_pkg::REG_IFR,    8'h00, 8'h00, 8'h00);
		queue_access(via_pkg::ACT_WRITE, via_pkg::REG_T2_HI,  8'h00, 8'h00, 8'h00);
		queue_access(via_pkg::ACT_WRITE, via_pkg::REG_IFR,    8'hFF, 8'h00, 8'h00);
		queue_access(via_pkg::ACT_WRITE, via_pkg::REG_IER,    8'h7F, 8'h00, 8'h00);
		queue_access(via_pkg::ACT_WRITE, via_pkg::REG_ACR,    8'hC0, 8'h00, 8'h00);
		queue_access(via_pkg::ACT_WRITE, via_pkg::REG_DDR_A,  8'h00, 8'h00, 8'h00);
		queue_access(via_pkg::ACT_WRITE, via_pkg::REG_PORT_A, 8'h00, 8'h00, 8'h00);
		queue_access(via_pkg::ACT_WRITE, via_pkg::REG_ACR,    8'h40, 8'h00, 8'h00);
		queue_access(via_pkg::ACT_READ,  via_pkg::REG_T1_HI,  8'hFF, 8'hFF, 8'hFF);

		for (int i = 0; i < RANDOM_ITEMS; i++)
			queue_access(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
				8'($urandom), 8'($urandom), 8'($urandom));
		total_items = pending.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pending.size() != 0 || req_valid || expected_rsp.size() != 0);
		repeat (4) @(negedge clk);

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
